// ----- src/qwt_pkg.sv -----
// -----------------------------------------------------------------------------
// qwt_pkg: shared types and constants of the quoted word tokenizer
// Character codes, result kinds, register indexes and the item bundles that
// pass between the scan logic and the result queue.
// -----------------------------------------------------------------------------
package qwt_pkg;

   localparam int CHAR_W      = 16;
   localparam int LEN_W       = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int MAX_RESULTS = 3;
   localparam int RSP_DEPTH_DEFAULT = 8;

   localparam logic [CHAR_W-1:0] CH_NUL       = 16'h0000;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
   localparam logic [CHAR_W-1:0] CH_QUOTE     = 16'h0022;
   localparam logic [CHAR_W-1:0] CH_BRACKET   = 16'h005B;
   localparam logic [CHAR_W-1:0] CH_SEMI      = 16'h003B;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_ESC       = 16'h001B;
   localparam logic [CHAR_W-1:0] CH_TAB       = 16'h0009;
   localparam logic [CHAR_W-1:0] CH_CR        = 16'h000D;
   localparam logic [CHAR_W-1:0] CH_ZERO      = 16'h0030;
   localparam logic [CHAR_W-1:0] CH_NINE      = 16'h0039;

   localparam logic [CHAR_W-1:0] DELIM_RESET   = 16'd59;
   localparam logic              COLON_RESET   = 1'b0;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 12'd1023;

   typedef enum logic [2:0] {
      KIND_CHAR  = 3'd0,
      KIND_SPACE = 3'd1,
      KIND_DELIM = 3'd2,
      KIND_END   = 3'd3,
      KIND_FULL  = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELIM   = 2'd0,
      CSR_COLON   = 2'd1,
      CSR_MAX_LEN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CHAR_W-1:0] delim;
      logic              colon;
      logic [LEN_W-1:0]  max_len;
   } cfg_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      kind_type          kind;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                         num;
      rsp_item_type [MAX_RESULTS-1:0]     item;
   } step_out_type;

endpackage

// ----- src/quoted_word_tokenizer_unit.sv -----
// -----------------------------------------------------------------------------
// quoted_word_tokenizer_unit: shell-style word tokenizer, one character per item
// Input register, combinational scan logic and a result queue.
// -----------------------------------------------------------------------------
// The unit takes one 16-bit character per cycle while req_tready is high and
// streams out the characters of the extracted word followed by a stop item;
// each input item yields zero to three result items, the last marked by
// rsp_tlast. An accepted item is held in the input register, the scan logic
// turns it into results combinationally and these are written into the result
// queue, whose head is on the rsp bus. The queue drains one item per cycle while
// rsp_tready is high, so the sustained rate is one character per cycle as long as
// a character yields one result on average; req_tready drops when the queue
// could not take three more results for the held character and a new one.
// Write configuration only while the unit is idle.
// -----------------------------------------------------------------------------
module quoted_word_tokenizer_unit
   import qwt_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CHAR_W-1:0]      req_tdata,   // [15:0] in_char
   input  logic [0:0]             req_tuser,   // [0] start_word
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [CHAR_W-1:0]      rsp_tdata,   // [15:0] out_char
   output logic [2:0]             rsp_tuser,   // [2:0] kind
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CHAR_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(RSP_DEPTH+1);

   cfg_type               cfg_ff, cfg_in;
   logic                  req_valid_ff, req_valid_in;
   logic                  req_start_ff;
   logic [CHAR_W-1:0]     req_char_ff;
   step_out_type          step_out;
   rsp_item_type          rsp_item;
   logic [CNT_W-1:0]      fill;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DELIM:   cfg_in.delim   = csr_wdata;
            CSR_COLON:   cfg_in.colon   = csr_wdata[0];
            CSR_MAX_LEN: cfg_in.max_len = csr_wdata[LEN_W-1:0];
            default:     ;
         endcase
      end
   end

   // leave room for the item in flight and the one being accepted
   assign req_tready = ({1'b0, fill} + (req_valid_ff ? (CNT_W+1)'(MAX_RESULTS) : '0))
                       <= (CNT_W+1)'(RSP_DEPTH - MAX_RESULTS);
   assign req_valid_in = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim   <= DELIM_RESET;
         cfg_ff.colon   <= COLON_RESET;
         cfg_ff.max_len <= MAX_LEN_RESET;
         req_valid_ff   <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         req_valid_ff   <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_start_ff <= req_tuser[0];
         req_char_ff  <= req_tdata;
      end
   end

   qwt_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid_ff),
      .in_start (req_start_ff),
      .in_char  (req_char_ff),
      .cfg      (cfg_ff),
      .step_out (step_out)
   );

   qwt_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (step_out),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_item  (rsp_item),
      .fill     (fill)
   );

   assign rsp_tdata = rsp_item.ch;
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

endmodule

// ----- src/qwt_scan.sv -----
// -----------------------------------------------------------------------------
// qwt_scan: per-character scan logic of the word tokenizer
// Holds the scan state and turns one registered character into up to three
// result items combinationally.
// -----------------------------------------------------------------------------
module qwt_scan
   import qwt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_start,
   input  logic [CHAR_W-1:0]   in_char,
   input  cfg_type             cfg,
   output step_out_type        step_out
);

   typedef enum logic [2:0] {
      ANSI_OFF    = 3'b001,
      ANSI_ANY    = 3'b010,
      ANSI_DIGITS = 3'b100
   } ansi_type;

   typedef struct packed {
      logic              skip;
      logic              done;
      logic              quotes;
      logic              literal;
      logic              esc;
      ansi_type          ansi;
      logic [CHAR_W-1:0] prev;
      logic [LEN_W-1:0]  count;
   } scan_type;

   typedef struct packed {
      scan_type     s;
      step_out_type out;
   } ctx_type;

   localparam scan_type SCAN_CLEAR = '{
      skip: 1'b1, done: 1'b0, quotes: 1'b0, literal: 1'b0, esc: 1'b0,
      ansi: ANSI_OFF, prev: '0, count: '0};

   scan_type scan_ff;
   scan_type scan_in;
   ctx_type  ctx;
   logic     proceed;

   function automatic ctx_type emit(ctx_type c, logic [CHAR_W-1:0] ch, kind_type k);
      ctx_type r;
      r = c;
      if (r.out.num != 2'(MAX_RESULTS)) begin
         r.out.item[r.out.num].ch   = ch;
         r.out.item[r.out.num].kind = k;
         r.out.item[r.out.num].last = 1'b0;
         r.out.num = r.out.num + 2'd1;
      end
      return r;
   endfunction

   function automatic ctx_type finish(ctx_type c, kind_type k);
      ctx_type r;
      r = emit(c, CH_NUL, k);
      r.s.done = 1'b1;
      r.s.esc  = 1'b0;
      r.s.ansi = ANSI_OFF;
      return r;
   endfunction

   function automatic ctx_type append(ctx_type c, logic [CHAR_W-1:0] ch,
                                      logic [LEN_W-1:0] max_len);
      ctx_type r;
      r = emit(c, ch, KIND_CHAR);
      r.s.count = r.s.count + LEN_W'(1);
      if (r.s.count >= max_len) begin
         r = finish(r, KIND_FULL);
      end
      return r;
   endfunction

   function automatic ctx_type plain(ctx_type c, logic [CHAR_W-1:0] ch, cfg_type cf);
      ctx_type           r;
      logic [CHAR_W-1:0] delim;
      r = c;
      delim = cf.colon ? CH_SEMI : cf.delim;
      if (ch == delim && r.s.prev != CH_BACKSLASH) begin
         if (!r.s.quotes) begin
            r = finish(r, KIND_DELIM);
         end else begin
            r.s.prev = ch;
            r = append(r, ch, cf.max_len);
         end
      end else if (!r.s.quotes && ch == CH_SPACE) begin
         r = finish(r, KIND_SPACE);
      end else begin
         r.s.prev = ch;
         r = append(r, ch, cf.max_len);
      end
      return r;
   endfunction

   function automatic ctx_type normal(ctx_type c, logic [CHAR_W-1:0] ch, cfg_type cf);
      ctx_type r;
      r = c;
      if (ch == CH_NUL) begin
         r = finish(r, KIND_END);
      end else if (r.s.literal) begin
         r.s.literal = 1'b0;
         r.s.prev = ch;
         r = append(r, ch, cf.max_len);
      end else if (ch == CH_BACKSLASH) begin
         r.s.literal = 1'b1;
         r.s.prev = ch;
      end else if (ch == CH_QUOTE) begin
         r.s.quotes = ~r.s.quotes;
         r.s.prev = ch;
      end else if (ch == CH_ESC &&
                   {1'b0, cf.max_len} > ({1'b0, r.s.count} + (LEN_W+1)'(2))) begin
         // hold the ESC back until the next character shows whether '[' follows
         r.s.esc = 1'b1;
      end else begin
         r = plain(r, ch, cf);
      end
      return r;
   endfunction

   always_comb begin
      ctx     = '0;
      ctx.s   = in_start ? SCAN_CLEAR : scan_ff;
      proceed = !ctx.s.done;
      if (proceed && ctx.s.skip) begin
         if (in_char inside {[CH_TAB:CH_CR], CH_SPACE}) begin
            ctx.s.prev = in_char;
            proceed = 1'b0;
         end else begin
            ctx.s.skip = 1'b0;
         end
      end
      if (proceed) begin
         if (ctx.s.count >= cfg.max_len) begin
            ctx = finish(ctx, (in_char == CH_NUL) ? KIND_END : KIND_FULL);
         end else if (ctx.s.esc) begin
            ctx.s.esc = 1'b0;
            if (in_char == CH_BRACKET) begin
               ctx = append(ctx, CH_ESC, cfg.max_len);
               if (!ctx.s.done) begin
                  ctx = append(ctx, CH_BRACKET, cfg.max_len);
               end
               ctx.s.prev = in_char;
               if (!ctx.s.done) begin
                  ctx.s.ansi = ANSI_ANY;
               end
            end else begin
               ctx = plain(ctx, CH_ESC, cfg);
               if (!ctx.s.done) begin
                  ctx = normal(ctx, in_char, cfg);
               end
            end
         end else begin
            case (ctx.s.ansi)
               ANSI_ANY: begin
                  if (in_char == CH_NUL) begin
                     ctx = finish(ctx, KIND_END);
                  end else begin
                     ctx.s.prev = in_char;
                     ctx.s.ansi = ANSI_DIGITS;
                     ctx = append(ctx, in_char, cfg.max_len);
                  end
               end
               ANSI_DIGITS: begin
                  if (in_char inside {[CH_ZERO:CH_NINE], CH_SEMI}) begin
                     ctx.s.prev = in_char;
                     ctx = append(ctx, in_char, cfg.max_len);
                  end else begin
                     ctx.s.ansi = ANSI_OFF;
                     ctx = normal(ctx, in_char, cfg);
                  end
               end
               default: begin
                  ctx = normal(ctx, in_char, cfg);
               end
            endcase
         end
      end
      if (ctx.out.num != 2'd0) begin
         ctx.out.item[ctx.out.num - 2'd1].last = 1'b1;
      end
   end

   assign scan_in = in_valid ? ctx.s : scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= SCAN_CLEAR;
      end else begin
         scan_ff <= scan_in;
      end
   end

   always_comb begin
      step_out = ctx.out;
      if (!in_valid) begin
         step_out.num = 2'd0;
      end
   end

endmodule

// ----- src/qwt_rsp_queue.sv -----
// -----------------------------------------------------------------------------
// qwt_rsp_queue: result queue of the word tokenizer
// Takes up to three result items per cycle and hands them out one per cycle while rd_ready is high.
// -----------------------------------------------------------------------------
module qwt_rsp_queue
   import qwt_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  step_out_type                  wr,
   output logic                          rd_valid,
   input  logic                          rd_ready,
   output rsp_item_type                  rd_item,
   output logic [$clog2(DEPTH+1)-1:0]    fill
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   rsp_item_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PTR_W-1:0]         addr [MAX_RESULTS+1];
   logic                     pop;

   function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      addr[0] = wr_ptr_ff;
      for (int k = 1; k <= MAX_RESULTS; k++) begin
         addr[k] = wrap_inc(addr[k-1]);
      end
   end

   assign pop       = rd_valid && rd_ready;
   assign wr_ptr_in = addr[wr.num];
   assign rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(wr.num) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < wr.num) begin
            mem_ff[addr[k]] <= wr.item[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem_ff[rd_ptr_ff];
   assign fill     = count_ff;

endmodule

// ----- bench/tb_quoted_word_tokenizer_unit.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_quoted_word_tokenizer_unit: self-checking bench for the word tokenizer
// Streams characters into the unit with random gaps on both channels and
// compares every result item against a cycle-free model of the scan logic.
// A directed opening exercises quoting, escapes, ANSI sequences and the stop
// conditions; random phases then vary the registers between idle points.
// -----------------------------------------------------------------------------
module tb_quoted_word_tokenizer_unit
   import qwt_pkg::*;
;

   localparam int                   RANDOM_ITEMS   = 170;
   localparam int                   SETTLE_CYCLES  = 8;
   localparam int                   WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED     = 2'd3;
   localparam logic [CHAR_W-1:0]    CH_MAX         = 16'hFFFF;

   // Scan model of the tokenizer plus the queue of results still owed.
   class word_scoreboard;
      logic [CHAR_W-1:0] delim;
      logic              colon;
      logic [LEN_W-1:0]  max_len;

      bit                skipping;
      bit                done;
      bit                quoted;
      bit                literal;
      bit                esc_held;
      logic [1:0]        ansi;
      logic [CHAR_W-1:0] prev;
      logic [LEN_W-1:0]  count;

      rsp_item_type      owed[$];
      rsp_item_type      step_out[$];
      int                n_errors;
      int                n_results;
      int                stops[5];

      function new();
         delim    = DELIM_RESET;
         colon    = COLON_RESET;
         max_len  = MAX_LEN_RESET;
         n_errors = 0;
         n_results = 0;
         foreach (stops[i]) stops[i] = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         skipping = 1'b1;
         done     = 1'b0;
         quoted   = 1'b0;
         literal  = 1'b0;
         esc_held = 1'b0;
         ansi     = 2'd0;
         prev     = CH_NUL;
         count    = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CHAR_W-1:0] value);
         case (idx)
            CSR_DELIM:   delim = value;
            CSR_COLON:   colon = value[0];
            CSR_MAX_LEN: max_len = value[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function void push(logic [CHAR_W-1:0] ch, kind_type kind);
         rsp_item_type r;
         if (step_out.size() >= MAX_RESULTS) return;
         r.ch   = ch;
         r.kind = kind;
         r.last = 1'b0;
         step_out.push_back(r);
      endfunction

      function void stop_word(kind_type kind);
         push(CH_NUL, kind);
         done     = 1'b1;
         esc_held = 1'b0;
         ansi     = 2'd0;
      endfunction

      function void copy_char(logic [CHAR_W-1:0] ch);
         push(ch, KIND_CHAR);
         count = count + 1'b1;
         if (count >= max_len) stop_word(KIND_FULL);
      endfunction

      function void plain_char(logic [CHAR_W-1:0] c);
         logic [CHAR_W-1:0] d;
         d = colon ? CH_SEMI : delim;
         if (c == d && prev != CH_BACKSLASH) begin
            if (!quoted) begin
               stop_word(KIND_DELIM);
               return;
            end
         end else if (!quoted && c == CH_SPACE) begin
            stop_word(KIND_SPACE);
            return;
         end
         prev = c;
         copy_char(c);
      endfunction

      function void scan_char(logic [CHAR_W-1:0] c);
         if (c == CH_NUL) begin
            stop_word(KIND_END);
            return;
         end
         if (literal) begin
            literal = 1'b0;
            prev = c;
            copy_char(c);
            return;
         end
         if (c == CH_BACKSLASH) begin
            literal = 1'b1;
            prev = c;
            return;
         end
         if (c == CH_QUOTE) begin
            quoted = !quoted;
            prev = c;
            return;
         end
         // hold an ESC back only while an ESC '[' pair still fits
         if (c == CH_ESC && (int'(max_len) - int'(count)) > 2) begin
            esc_held = 1'b1;
            return;
         end
         plain_char(c);
      endfunction

      // Returns 1 when the item can still affect the current word.
      function bit note_input(bit start, logic [CHAR_W-1:0] c);
         step_out.delete();
         if (start) clear_scan();
         if (done) return 1'b0;
         if (skipping) begin
            if ((c >= 16'd9 && c <= 16'd13) || c == CH_SPACE) begin
               prev = c;
               return 1'b1;
            end
            skipping = 1'b0;
         end
         if (count >= max_len) begin
            stop_word(c == CH_NUL ? KIND_END : KIND_FULL);
         end else if (esc_held) begin
            esc_held = 1'b0;
            if (c == CH_BRACKET) begin
               copy_char(CH_ESC);
               if (!done) copy_char(CH_BRACKET);
               prev = c;
               if (!done) ansi = 2'd1;
            end else begin
               plain_char(CH_ESC);
               if (!done) scan_char(c);
            end
         end else if (ansi == 2'd1) begin
            if (c == CH_NUL) begin
               stop_word(KIND_END);
            end else begin
               prev = c;
               ansi = 2'd2;
               copy_char(c);
            end
         end else if (ansi == 2'd2) begin
            if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI) begin
               prev = c;
               copy_char(c);
            end else begin
               ansi = 2'd0;
               scan_char(c);
            end
         end else begin
            scan_char(c);
         end
         if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
         foreach (step_out[i]) owed.push_back(step_out[i]);
         return 1'b1;
      endfunction

      function void check_result(logic [CHAR_W-1:0] ch, logic [2:0] kind, logic last);
         rsp_item_type want;
         n_results++;
         if (owed.size() == 0) begin
            n_errors++;
            $error("unexpected result: out_char %h kind %0d last_of_run %0b", ch, kind, last);
            return;
         end
         want = owed.pop_front();
         if (ch !== want.ch) begin
            n_errors++;
            $error("out_char mismatch: expected %h, actual %h", want.ch, ch);
         end
         if (kind !== want.kind) begin
            n_errors++;
            $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
         end
         if (last !== want.last) begin
            n_errors++;
            $error("last_of_run mismatch: expected %0b, actual %0b", want.last, last);
         end
         if (want.kind != KIND_CHAR) stops[want.kind]++;
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [CHAR_W-1:0]    req_tdata;
   logic [0:0]           req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [CHAR_W-1:0]    rsp_tdata;
   logic [2:0]           rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CHAR_W-1:0]    csr_wdata;

   word_scoreboard tok_model = new();
   bit             tx_idle_on = 1'b1;
   bit             rx_idle_on = 1'b1;
   int             n_items = 0;
   int             n_live = 0;

   quoted_word_tokenizer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] in_char
      .req_tuser  (req_tuser),    // [0] start_word
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] out_char
      .rsp_tuser  (rsp_tuser),    // [2:0] kind
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_char(input bit start, input logic [CHAR_W-1:0] ch);
      int gap;
      gap = tx_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      n_items++;
      if (tok_model.note_input(start, ch)) n_live++;
   endtask

   task automatic send_str(input bit start, input string s);
      for (int i = 0; i < s.len(); i++) send_char(start && i == 0, {8'h00, s[i]});
   endtask

   // Hold the sender until every owed result is out and the pipe is empty.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (tok_model.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CHAR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tok_model.write_reg(idx, value);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] random_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 16'h0061 + 16'($urandom_range(0, 25));
      if (r < 47) return CH_SPACE;
      if (r < 53) return CH_QUOTE;
      if (r < 59) return CH_BACKSLASH;
      if (r < 65) return CH_ESC;
      if (r < 70) return CH_BRACKET;
      if (r < 77) return CH_ZERO + 16'($urandom_range(0, 9));
      if (r < 82) return CH_SEMI;
      if (r < 85) return tok_model.delim;
      if (r < 88) return CH_NUL;
      if (r < 92) return CH_TAB + 16'($urandom_range(0, 4));
      return 16'($urandom);
   endfunction

   task automatic random_config();
      int               r;
      logic [CHAR_W-1:0] v;
      r = $urandom_range(0, 19);
      if (r < 10)      v = CH_SEMI;
      else if (r < 13) v = 16'($urandom);
      else if (r < 15) v = CH_ESC;
      else if (r < 17) v = 16'h0061 + 16'($urandom_range(0, 25));
      else if (r < 18) v = CH_MAX;
      else if (r < 19) v = CH_NUL;
      else             v = CH_QUOTE;
      write_reg(CSR_DELIM, v);
      // upper bits of the narrow registers carry junk that must be dropped
      write_reg(CSR_COLON, 16'($urandom));
      r = $urandom_range(0, 9);
      if (r < 4)      v = 16'($urandom_range(1, 6));
      else if (r < 7) v = 16'($urandom_range(7, 20));
      else if (r < 8) v = 16'h0000;
      else if (r < 9) v = 16'h0FFF;
      else            v = 16'd1023;
      v[15:12] = 4'($urandom);
      write_reg(CSR_MAX_LEN, v);
      if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, 16'($urandom));
   endtask

   task automatic random_word();
      int n;
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         // noise: arbitrary characters with stray start flags
         n = $urandom_range(1, 4);
         repeat (n) send_char(1'($urandom_range(0, 1)), 16'($urandom));
         return;
      end
      send_char(1'b1, ($urandom_range(0, 2) == 0) ? CH_SPACE : random_char());
      if ($urandom_range(0, 3) == 0) send_char(1'b0, CH_TAB + 16'($urandom_range(0, 4)));
      n = $urandom_range(1, 10);
      repeat (n) send_char(1'b0, random_char());
      r = $urandom_range(0, 3);
      if (r == 0)      send_char(1'b0, CH_SPACE);
      else if (r == 1) send_char(1'b0, tok_model.colon ? CH_SEMI : tok_model.delim);
      else if (r == 2) send_char(1'b0, CH_NUL);
      else             send_char(1'b0, CH_SEMI);
      if ($urandom_range(0, 4) == 0) send_char(1'b0, random_char());
   endtask

   initial begin : rsp_sink
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            tok_model.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rx_idle_on) stall = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAIL quoted_word_tokenizer_unit");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int since_cfg;
      int phase_len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // leading whitespace, escaped delimiter, quoted space and delimiter
      send_char(1'b1, CH_SPACE);
      send_char(1'b0, CH_TAB);
      send_str(1'b0, "a\\;\" ;\"");
      send_char(1'b0, CH_MAX);
      send_char(1'b0, CH_SPACE);
      send_str(1'b0, "x");
      // ANSI sequence, then end of text
      send_char(1'b1, CH_ESC);
      send_str(1'b0, "[3;m");
      send_char(1'b0, CH_NUL);
      // NUL right after ESC '['
      send_char(1'b1, CH_ESC);
      send_char(1'b0, CH_BRACKET);
      send_char(1'b0, CH_NUL);
      // ESC not followed by '[', then the delimiter
      send_char(1'b1, CH_ESC);
      send_str(1'b0, "q;");
      // backslash then NUL
      send_char(1'b1, CH_BACKSLASH);
      send_char(1'b0, CH_NUL);
      drain_results();

      // lower the limit under a word in progress
      write_reg(CSR_MAX_LEN, 16'd10);
      send_str(1'b1, "abc");
      drain_results();
      write_reg(CSR_MAX_LEN, 16'd2);
      send_str(1'b0, "e");
      drain_results();
      // zero limit, with junk in the upper bits
      write_reg(CSR_MAX_LEN, 16'hF000);
      send_char(1'b1, CH_SPACE);
      send_str(1'b0, "k");
      send_char(1'b1, CH_NUL);
      drain_results();
      // ESC as delimiter, largest limit, colon mode
      write_reg(CSR_MAX_LEN, 16'h0FFF);
      write_reg(CSR_DELIM, CH_ESC);
      send_char(1'b1, CH_ESC);
      send_str(1'b0, "x");
      drain_results();
      write_reg(CSR_COLON, 16'hFFFF);
      write_reg(CSR_UNUSED, 16'h1234);
      send_str(1'b1, "A\033;");
      drain_results();

      since_cfg = 0;
      phase_len = 0;
      while (n_live < RANDOM_ITEMS + 0 || since_cfg == 0) begin
         if (since_cfg >= phase_len) begin
            drain_results();
            random_config();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            phase_len  = $urandom_range(20, 45);
            since_cfg  = 0;
         end
         random_word();
         since_cfg++;
         if (n_live >= RANDOM_ITEMS + 40) break;
      end

      req_tvalid <= 1'b0;
      while (tok_model.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tok_model.owed.size() != 0) begin
         tok_model.n_errors++;
         $error("%0d expected results never arrived", tok_model.owed.size());
      end

      $display("Run covered %0d input items and %0d result items over varied registers.",
               n_items, tok_model.n_results);
      $display("Word stops seen: space %0d, delimiter %0d, end of text %0d, length full %0d.",
               tok_model.stops[KIND_SPACE], tok_model.stops[KIND_DELIM],
               tok_model.stops[KIND_END], tok_model.stops[KIND_FULL]);
      if (tok_model.n_errors == 0) begin
         $display("PASS quoted_word_tokenizer_unit");
      end else begin
         $display("FAIL quoted_word_tokenizer_unit");
      end
      $finish;
   end

endmodule
